[rtl/wfd_pkg.sv]
// Shared constants, types and codes of the weather frame decoder.
package wfd_pkg;

   // Frame buffer geometry
   localparam int FRAME_BYTES_DEF = 32;
   localparam int HDR_BYTES       = 12;   // bytes 0..11 feed the decode
   localparam int HDR_IDX_W       = 4;
   localparam int TRIGGER_POS     = 11;
   localparam int WRAP_POS        = 2;
   localparam int CSUM_BYTES      = 10;
   localparam int SUM_HALF        = 5;
   localparam int SUM_HALF_W      = 11;   // five bytes sum below 2048

   // Channel tables
   localparam int CHANNELS  = 16;
   localparam int CH_W      = 4;
   localparam int AGE_W     = 16;
   localparam int TIMEOUT_W = 16;

   localparam logic [7:0]           SYNC_BYTE     = 8'hFF;
   localparam logic [7:0]           STATION_ID    = 8'h42;
   localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 16'd1800;
   localparam logic [AGE_W-1:0]     AGE_MAX       = 16'hFFFF;

   localparam int QUEUE_DEPTH = 2;

   typedef enum logic {
      OP_FRAME,
      OP_TICK
   } op_type;

   typedef enum logic [1:0] {
      KIND_READING  = 2'd0,
      KIND_STALE    = 2'd1,
      KIND_CSUM_ERR = 2'd2
   } kind_type;

   // Work handed from the front to the back
   typedef struct packed {
      op_type                      op;
      logic [HDR_BYTES-1:0][7:0]   frame;
   } cmd_type;

   typedef struct packed {
      logic    valid;
      cmd_type cmd;
   } q_item_type;

   typedef struct packed {
      kind_type           kind;
      logic [CH_W-1:0]    channel;
      logic signed [15:0] temp_tenths;
      logic [7:0]         humidity;
      logic               battery_ok;
      logic               first_seen;
      logic               last;
   } result_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SUM,
      ST_CHECK,
      ST_AGE,
      ST_SCAN
   } state_type;

endpackage

[rtl/wfd_if.sv]
// Handshake channels of the weather frame decoder.
interface wfd_req_if;
   logic       valid;
   logic       ready;
   logic       action;
   logic [7:0] data_byte;

   modport source (output valid, action, data_byte, input ready);
   modport sink   (input valid, action, data_byte, output ready);
endinterface

interface wfd_rsp_if;
   logic               valid;
   logic               ready;
   logic [1:0]         kind;
   logic [3:0]         channel;
   logic signed [15:0] temp_tenths;
   logic [7:0]         humidity;
   logic               battery_ok;
   logic               first_seen;
   logic               last;

   modport source (output valid, kind, channel, temp_tenths, humidity, battery_ok,
                   first_seen, last, input ready);
   modport sink   (input valid, kind, channel, temp_tenths, humidity, battery_ok,
                   first_seen, last, output ready);
endinterface

[rtl/weather_frame_decoder.sv]
// Weather frame decoder: the front takes one item per cycle while its two-entry
// command queue has room; a data byte updates the frame position and header
// bytes and queues only a completed frame, so bytes stream at one per cycle too.
// The back works one command at a time: a frame (byte 11 with identifier 0x42)
// is popped, summed in halves, then compared and emitted; a tick is popped and
// aged, then sends one stale item per cycle, while the output register is free,
// for each channel that goes stale. Results sit in an output register, so the
// back keeps working while the last result waits. The timeout register, written
// via csr_wr_en and csr_wr_data, resets to 1800 ticks; no clearing pass needed.
module weather_frame_decoder #(
   parameter int FRAME_BYTES = wfd_pkg::FRAME_BYTES_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   wfd_req_if.sink                       req_ch,
   wfd_rsp_if.source                     rsp_ch,
   input  logic                          csr_wr_en,
   input  logic [wfd_pkg::TIMEOUT_W-1:0] csr_wr_data
);
   import wfd_pkg::*;

   q_item_type q_push, q_head;
   logic       q_full, q_pop;

   wfd_front #(
      .FRAME_BYTES (FRAME_BYTES)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .req_ch   (req_ch),
      .q_full   (q_full),
      .push_out (q_push)
   );

   wfd_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock   (clock),
      .reset   (reset),
      .push_in (q_push),
      .full    (q_full),
      .pop     (q_pop),
      .head    (q_head)
   );

   wfd_back u_back (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .head        (q_head),
      .pop         (q_pop),
      .rsp_ch      (rsp_ch)
   );

   // The front never pushes into a full queue
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      q_push.valid |-> !q_full)
      else $error("push into full command queue");

   // The back pops only real commands
   a_pop_valid: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_head.valid)
      else $error("pop from empty command queue");

   // A frame gives exactly one result
   a_frame_last: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && (rsp_ch.kind == KIND_READING || rsp_ch.kind == KIND_CSUM_ERR)
      |-> rsp_ch.last)
      else $error("frame result not marked last");

   // A checksum error carries no reading
   a_csum_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && rsp_ch.kind == KIND_CSUM_ERR
      |-> rsp_ch.channel == '0 && rsp_ch.temp_tenths == '0 && rsp_ch.humidity == '0
          && !rsp_ch.battery_ok && !rsp_ch.first_seen)
      else $error("checksum error carries reading fields");

endmodule

[rtl/wfd_queue.sv]
// Short command queue between the front and the back.
module wfd_queue #(
   parameter int DEPTH = wfd_pkg::QUEUE_DEPTH
) (
   input  logic                clock,
   input  logic                reset,
   input  wfd_pkg::q_item_type push_in,
   output logic                full,
   input  logic                pop,
   output wfd_pkg::q_item_type head
);
   import wfd_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   cmd_type          entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full       = (count_ff == CNT_W'(DEPTH));
   assign head.valid = (count_ff != '0);
   assign head.cmd   = entry_ff[rd_ptr_ff];
   assign do_push    = push_in.valid && !full;
   assign do_pop     = pop && head.valid;

   // Advance pointers and occupancy
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store pushed commands
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_in.cmd;
      end
   end

endmodule

[rtl/wfd_front.sv]
// Front part: takes items, tracks the frame position and header bytes, queues work.
module wfd_front #(
   parameter int FRAME_BYTES = wfd_pkg::FRAME_BYTES_DEF
) (
   input  logic                clock,
   input  logic                reset,
   wfd_req_if.sink             req_ch,
   input  logic                q_full,
   output wfd_pkg::q_item_type push_out
);
   import wfd_pkg::*;

   localparam int POS_W = $clog2(FRAME_BYTES);

   logic [POS_W-1:0] pos_ff, pos_in;
   logic [7:0]       frame_ff [HDR_BYTES];
   logic [7:0]       last_ff;
   logic             accept, take_byte, trigger, restart;
   logic [POS_W-1:0] pos_m1;
   logic [POS_W:0]   pos_inc;
   logic [7:0]       prev_byte;

   assign req_ch.ready = !q_full;
   assign accept       = req_ch.valid && req_ch.ready;
   assign take_byte    = accept && !req_ch.action;

   // Find the byte just before the current position
   always_comb begin
      pos_m1 = pos_ff - POS_W'(1);
      if (pos_ff <= POS_W'(HDR_BYTES)) begin
         prev_byte = frame_ff[pos_m1[HDR_IDX_W-1:0]];
      end else begin
         prev_byte = last_ff;
      end
   end

   // Restart on a sync pair, wrap past the end of the buffer
   always_comb begin
      restart = (pos_ff != '0) && (prev_byte == SYNC_BYTE) && (req_ch.data_byte == SYNC_BYTE);
      pos_inc = {1'b0, pos_ff} + (POS_W + 1)'(1);
      pos_in  = pos_ff;
      if (take_byte) begin
         if (restart) begin
            pos_in = '0;
         end else if (pos_inc == (POS_W + 1)'(FRAME_BYTES)) begin
            pos_in = POS_W'(WRAP_POS);
         end else begin
            pos_in = pos_inc[POS_W-1:0];
         end
      end
   end

   // Queue a decode on the last checksum byte with our identifier, and every tick
   always_comb begin
      trigger = (pos_ff == POS_W'(TRIGGER_POS)) && (frame_ff[1] == STATION_ID);
      push_out.valid  = accept && (req_ch.action || trigger);
      push_out.cmd.op = req_ch.action ? OP_TICK : OP_FRAME;
      for (int i = 0; i < HDR_BYTES; i++) begin
         push_out.cmd.frame[i] = frame_ff[i];
      end
      push_out.cmd.frame[TRIGGER_POS] = req_ch.data_byte;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= POS_W'(WRAP_POS);
      end else begin
         pos_ff <= pos_in;
      end
   end

   // Hold header bytes; only bytes 0 and 1 have a reset value
   always_ff @(posedge clock) begin
      if (reset) begin
         frame_ff[0] <= '0;
         frame_ff[1] <= '0;
      end else if (take_byte) begin
         for (int i = 0; i < HDR_BYTES; i++) begin
            if (pos_ff == POS_W'(i)) begin
               frame_ff[i] <= req_ch.data_byte;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take_byte) begin
         last_ff <= req_ch.data_byte;
      end
   end

endmodule

[rtl/wfd_back.sv]
// Back part: checks and decodes frames, ages channels, emits results.
module wfd_back (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_wr_en,
   input  logic [wfd_pkg::TIMEOUT_W-1:0] csr_wr_data,
   input  wfd_pkg::q_item_type           head,
   output logic                          pop,
   wfd_rsp_if.source                     rsp_ch
);
   import wfd_pkg::*;

   state_type             state_ff, state_in;
   cmd_type               cmd_ff;
   logic [SUM_HALF_W-1:0] sum_lo_ff, sum_hi_ff, sum_lo, sum_hi;
   logic [TIMEOUT_W-1:0]  timeout_ff;
   logic [CHANNELS-1:0]   seen_ff, stale_ff, pending_ff, stale_new;
   logic [AGE_W-1:0]      age_ff  [CHANNELS];
   logic [AGE_W-1:0]      age_next[CHANNELS];
   logic [7:0]            hum_ff  [CHANNELS];
   logic                  out_valid_ff;
   result_type            out_ff, out_data;
   logic                  slot_free, load_cmd, load_sum, out_load, age_tick, reading_we;
   logic                  scan_emit, csum_ok;
   logic [CHANNELS-1:0]   scan_oh, scan_rest;
   logic [CH_W-1:0]       scan_ch, ch;
   logic [14:0]           mag;
   logic [15:0]           temp;

   assign slot_free = !out_valid_ff || rsp_ch.ready;
   assign ch        = cmd_ff.frame[2][CH_W-1:0];

   // Checksum halves, five bytes each
   always_comb begin
      sum_lo = '0;
      sum_hi = '0;
      for (int i = 0; i < SUM_HALF; i++) begin
         sum_lo = sum_lo + SUM_HALF_W'(cmd_ff.frame[i]);
         sum_hi = sum_hi + SUM_HALF_W'(cmd_ff.frame[i + SUM_HALF]);
      end
   end

   // Sign-magnitude temperature to two's complement
   always_comb begin
      mag     = {cmd_ff.frame[4][6:0], cmd_ff.frame[3]};
      temp    = cmd_ff.frame[4][7] ? 16'(16'd0 - {1'b0, mag}) : {1'b0, mag};
      csum_ok = (16'(sum_lo_ff) + 16'(sum_hi_ff))
                == {cmd_ff.frame[TRIGGER_POS], cmd_ff.frame[TRIGGER_POS - 1]};
   end

   // Age each lane by one tick and flag newly stale channels
   always_comb begin
      for (int i = 0; i < CHANNELS; i++) begin
         age_next[i]  = (age_ff[i] == AGE_MAX) ? age_ff[i] : age_ff[i] + AGE_W'(1);
         stale_new[i] = seen_ff[i] && !stale_ff[i] && (age_next[i] > timeout_ff);
      end
   end

   // Pick the lowest pending stale channel
   always_comb begin
      scan_oh   = pending_ff & (~pending_ff + CHANNELS'(1));
      scan_rest = pending_ff & ~scan_oh;
      scan_ch   = '0;
      for (int i = 0; i < CHANNELS; i++) begin
         if (scan_oh[i]) begin
            scan_ch = CH_W'(i);
         end
      end
   end

   // Sequence one command at a time
   always_comb begin
      state_in   = state_ff;
      pop        = 1'b0;
      load_cmd   = 1'b0;
      load_sum   = 1'b0;
      out_load   = 1'b0;
      age_tick   = 1'b0;
      reading_we = 1'b0;
      scan_emit  = 1'b0;
      out_data   = '0;
      case (state_ff)
         ST_IDLE: begin
            if (head.valid) begin
               pop      = 1'b1;
               load_cmd = 1'b1;
               state_in = (head.cmd.op == OP_TICK) ? ST_AGE : ST_SUM;
            end
         end
         ST_SUM: begin
            load_sum = 1'b1;
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            if (slot_free) begin
               out_load      = 1'b1;
               out_data.last = 1'b1;
               if (csum_ok) begin
                  reading_we          = 1'b1;
                  out_data.kind       = KIND_READING;
                  out_data.channel    = ch;
                  out_data.temp_tenths = temp;
                  out_data.humidity   = cmd_ff.frame[5];
                  out_data.battery_ok = !cmd_ff.frame[0][6];
                  out_data.first_seen = !seen_ff[ch];
               end else begin
                  out_data.kind = KIND_CSUM_ERR;
               end
               state_in = ST_IDLE;
            end
         end
         ST_AGE: begin
            age_tick = 1'b1;
            state_in = (stale_new != '0) ? ST_SCAN : ST_IDLE;
         end
         ST_SCAN: begin
            if (slot_free) begin
               out_load          = 1'b1;
               scan_emit         = 1'b1;
               out_data.kind     = KIND_STALE;
               out_data.channel  = scan_ch;
               out_data.humidity = hum_ff[scan_ch];
               out_data.last     = (scan_rest == '0);
               if (scan_rest == '0) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         timeout_ff   <= TIMEOUT_RESET;
         seen_ff      <= '0;
         stale_ff     <= '0;
         pending_ff   <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_wr_en) begin
            timeout_ff <= csr_wr_data;
         end
         if (age_tick) begin
            stale_ff   <= stale_ff | stale_new;
            pending_ff <= stale_new;
         end else if (scan_emit) begin
            pending_ff <= scan_rest;
         end else if (reading_we) begin
            seen_ff[ch]  <= 1'b1;
            stale_ff[ch] <= 1'b0;
         end
         if (out_load) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   // Command, sums, channel ages and humidity, result register
   always_ff @(posedge clock) begin
      if (load_cmd) begin
         cmd_ff <= head.cmd;
      end
      if (load_sum) begin
         sum_lo_ff <= sum_lo;
         sum_hi_ff <= sum_hi;
      end
      for (int i = 0; i < CHANNELS; i++) begin
         if (age_tick && seen_ff[i]) begin
            age_ff[i] <= age_next[i];
         end else if (reading_we && (ch == CH_W'(i))) begin
            age_ff[i] <= '0;
            hum_ff[i] <= cmd_ff.frame[5];
         end
      end
      if (out_load) begin
         out_ff <= out_data;
      end
   end

   assign rsp_ch.valid       = out_valid_ff;
   assign rsp_ch.kind        = out_ff.kind;
   assign rsp_ch.channel     = out_ff.channel;
   assign rsp_ch.temp_tenths = out_ff.temp_tenths;
   assign rsp_ch.humidity    = out_ff.humidity;
   assign rsp_ch.battery_ok  = out_ff.battery_ok;
   assign rsp_ch.first_seen  = out_ff.first_seen;
   assign rsp_ch.last        = out_ff.last;

endmodule

[sim/wfd_checker.sv]
`timescale 1ns / 100ps
// Checker: predicts the decoder's results from accepted items and compares them in order.
module wfd_checker (
   input  logic                          clock,
   input  logic                          reset,
   wfd_req_if                            req_ch,
   wfd_rsp_if                            rsp_ch,
   input  logic                          csr_wr_en,
   input  logic [wfd_pkg::TIMEOUT_W-1:0] csr_wr_data,
   output int                            fail_count,
   output int unsigned                   results_pending
);
   import wfd_pkg::*;

   localparam int FRAME_LEN = FRAME_BYTES_DEF;

   // Predicted decoder state
   logic [7:0]           frame_buf [FRAME_LEN];
   int unsigned          frame_pos;
   logic                 ch_seen   [CHANNELS];
   logic                 ch_stale  [CHANNELS];
   logic [AGE_W-1:0]     ch_age    [CHANNELS];
   logic [7:0]           ch_hum    [CHANNELS];
   logic [TIMEOUT_W-1:0] stale_limit;
   result_type           expected_results [$];

   task automatic compare_field(input string name, input logic [15:0] want,
                                input logic [15:0] got);
      if (want !== got) begin
         $error("%s: expected %h, got %h", name, want, got);
         fail_count++;
      end
   endtask

   // Store one byte, decode on byte 11 of a frame with our identifier, track sync pairs
   task automatic predict_byte(input logic [7:0] value);
      int unsigned     pos;
      logic [15:0]     sum;
      logic [14:0]     mag;
      logic [CH_W-1:0] ch;
      result_type      r;
      pos = frame_pos;
      if (pos >= FRAME_LEN) pos = WRAP_POS;
      frame_buf[pos] = value;
      if (pos == TRIGGER_POS && frame_buf[1] == STATION_ID) begin
         sum = '0;
         for (int i = 0; i < CSUM_BYTES; i++) sum = sum + 16'(frame_buf[i]);
         r = '0;
         r.last = 1'b1;
         if (sum != {frame_buf[11], frame_buf[10]}) begin
            r.kind = KIND_CSUM_ERR;
         end else begin
            ch  = frame_buf[2][CH_W-1:0];
            mag = {frame_buf[4][6:0], frame_buf[3]};
            r.kind        = KIND_READING;
            r.channel     = ch;
            r.temp_tenths = frame_buf[4][7] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
            r.humidity    = frame_buf[5];
            r.battery_ok  = ~frame_buf[0][6];
            r.first_seen  = ~ch_seen[ch];
            ch_seen[ch]  = 1'b1;
            ch_stale[ch] = 1'b0;
            ch_age[ch]   = '0;
            ch_hum[ch]   = frame_buf[5];
         end
         expected_results.push_back(r);
      end
      // restart on a sync pair, otherwise advance and wrap past the end of the buffer
      if (pos > 0 && frame_buf[pos-1] == SYNC_BYTE && frame_buf[pos] == SYNC_BYTE) begin
         pos = 0;
      end else begin
         pos++;
      end
      if (pos >= FRAME_LEN) pos = WRAP_POS;
      frame_pos = pos;
   endtask

   // Age every seen channel and report each one that just went stale
   task automatic predict_tick();
      result_type r;
      result_type batch [$];
      for (int i = 0; i < CHANNELS; i++) begin
         if (ch_seen[i]) begin
            if (ch_age[i] != AGE_MAX) ch_age[i]++;
            if (ch_age[i] > stale_limit && !ch_stale[i]) begin
               ch_stale[i] = 1'b1;
               r = '0;
               r.kind     = KIND_STALE;
               r.channel  = CH_W'(i);
               r.humidity = ch_hum[i];
               batch.push_back(r);
            end
         end
      end
      if (batch.size() > 0) batch[batch.size()-1].last = 1'b1;
      foreach (batch[i]) expected_results.push_back(batch[i]);
   endtask

   always @(posedge clock) begin : monitor
      result_type want;
      if (reset) begin
         foreach (frame_buf[i]) frame_buf[i] = '0;
         frame_pos = WRAP_POS;
         for (int i = 0; i < CHANNELS; i++) begin
            ch_seen[i]  = 1'b0;
            ch_stale[i] = 1'b0;
            ch_age[i]   = '0;
            ch_hum[i]   = '0;
         end
         stale_limit = TIMEOUT_RESET;
         expected_results.delete();
         fail_count      = 0;
         results_pending = 0;
      end else begin
         if (csr_wr_en === 1'b1) stale_limit = csr_wr_data;
         // compare each returned item with the oldest prediction
         if (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
            if (expected_results.size() == 0) begin
               $error("unexpected result: kind %0d channel %0d", rsp_ch.kind, rsp_ch.channel);
               fail_count++;
            end else begin
               want = expected_results.pop_front();
               compare_field("kind", 16'(want.kind), 16'(rsp_ch.kind));
               compare_field("channel", 16'(want.channel), 16'(rsp_ch.channel));
               compare_field("temp_tenths", want.temp_tenths, rsp_ch.temp_tenths);
               compare_field("humidity", 16'(want.humidity), 16'(rsp_ch.humidity));
               compare_field("battery_ok", 16'(want.battery_ok), 16'(rsp_ch.battery_ok));
               compare_field("first_seen", 16'(want.first_seen), 16'(rsp_ch.first_seen));
               compare_field("last", 16'(want.last), 16'(rsp_ch.last));
            end
         end
         // predict from each accepted item
         if (req_ch.valid === 1'b1 && req_ch.ready === 1'b1) begin
            if (op_type'(req_ch.action) == OP_TICK) begin
               predict_tick();
            end else begin
               predict_byte(req_ch.data_byte);
            end
         end
         results_pending = expected_results.size();
      end
   end

endmodule

[sim/testbench.sv]
`timescale 1ns / 100ps
// Top of the decoder testbench: clock, reset, stimulus, receiver pacing and verdict.
module testbench;
   import wfd_pkg::*;

   localparam int PHASE_ITEMS   = 52;
   localparam int PHASE_FRAMES  = 3;
   localparam int SETTLE_CYCLES = 40;
   localparam int HOLD_CYCLES   = 400;
   localparam int AGING_TICKS   = 20;   // age a channel well past the lowered timeout

   logic                 clock = 1'b0;
   logic                 reset;
   logic                 csr_wr_en;
   logic [TIMEOUT_W-1:0] csr_wr_data;
   int                   fail_count;
   int unsigned          results_pending;

   int          send_idle_pct = 0;
   int          rsp_stall_pct = 0;
   int          rsp_hold_len  = 0;
   int unsigned phase_items   = 0;
   int unsigned phase_frames  = 0;

   wfd_req_if req_ch ();
   wfd_rsp_if rsp_ch ();

   weather_frame_decoder u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   wfd_checker u_checker (
      .clock           (clock),
      .reset           (reset),
      .req_ch          (req_ch),
      .rsp_ch          (rsp_ch),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data),
      .fail_count      (fail_count),
      .results_pending (results_pending)
   );

   always #10 clock = ~clock;

   // Offer one item after a random idle gap and hold it until accepted
   task automatic send_item(input op_type op, input logic [7:0] value);
      while (send_idle_pct != 0 && $urandom_range(99, 0) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid     <= 1'b1;
      req_ch.action    <= op;
      req_ch.data_byte <= value;
      @(posedge clock);
      while (req_ch.ready !== 1'b1) @(posedge clock);
      phase_items++;
   endtask

   // Send a sync pair and a twelve-byte header with its checksum, optionally corrupted
   task automatic send_frame(input logic [7:0] b0, input logic [7:0] id,
                             input logic [7:0] ch_byte, input logic [7:0] t_lo,
                             input logic [7:0] t_hi, input logic [7:0] hum,
                             input bit bad_sum);
      logic [7:0]  hdr [HDR_BYTES];
      logic [15:0] sum;
      hdr[0] = b0;
      hdr[1] = id;
      hdr[2] = ch_byte;
      hdr[3] = t_lo;
      hdr[4] = t_hi;
      hdr[5] = hum;
      for (int i = 6; i < CSUM_BYTES; i++) hdr[i] = 8'($urandom_range(254, 0));
      sum = '0;
      for (int i = 0; i < CSUM_BYTES; i++) sum = sum + 16'(hdr[i]);
      if (bad_sum) sum = sum ^ 16'($urandom_range(65535, 1));
      hdr[10] = sum[7:0];
      hdr[11] = sum[15:8];
      send_item(OP_FRAME, SYNC_BYTE);
      send_item(OP_FRAME, SYNC_BYTE);
      for (int i = 0; i < HDR_BYTES; i++) send_item(OP_FRAME, hdr[i]);
      phase_frames++;
   endtask

   task automatic send_random_frame();
      send_frame(8'($urandom),
                 ($urandom_range(9, 0) == 0) ? 8'($urandom) : STATION_ID,
                 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                 $urandom_range(7, 0) == 0);
   endtask

   // Drop valid, wait for every predicted result, then let the back end go quiet
   task automatic settle();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (results_pending != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_timeout(input logic [TIMEOUT_W-1:0] value);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   // Random traffic: mostly well-formed frames, ticks in bursts, noise bytes
   task automatic run_phase(input int idle_pct, input int stall_pct,
                            input logic [TIMEOUT_W-1:0] timeout, input bit with_hold);
      int pick;
      int len;
      settle();
      write_timeout(timeout);
      send_idle_pct = idle_pct;
      rsp_stall_pct = stall_pct;
      phase_items   = 0;
      phase_frames  = 0;
      if (with_hold) begin
         rsp_hold_len = HOLD_CYCLES;
         repeat (6) send_random_frame();
      end
      while (phase_items < PHASE_ITEMS || phase_frames < PHASE_FRAMES) begin
         pick = $urandom_range(9, 0);
         if (pick < 5) begin
            send_random_frame();
         end else if (pick < 8) begin
            repeat ($urandom_range(3, 1)) send_item(OP_TICK, 8'($urandom));
         end else begin
            len = ($urandom_range(3, 0) == 0) ? $urandom_range(40, 20) : $urandom_range(6, 1);
            repeat (len) begin
               send_item(OP_FRAME, ($urandom_range(3, 0) == 0) ? SYNC_BYTE : 8'($urandom));
            end
         end
      end
   endtask

   // Receiver: random stalls, or a long hold when one is requested
   initial begin
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_hold_len != 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (rsp_hold_len) @(posedge clock);
            rsp_hold_len = 0;
         end else begin
            rsp_ch.ready <= !(rsp_stall_pct != 0 && $urandom_range(99, 0) < rsp_stall_pct);
         end
      end
   end

   // Guard against a hung run
   initial begin
      #40_000_000;
      $display("CHECK FAILED");
      $finish;
   end

   initial begin
      reset            <= 1'b1;
      csr_wr_en        <= 1'b0;
      csr_wr_data      <= '0;
      req_ch.valid     <= 1'b0;
      req_ch.action    <= OP_FRAME;
      req_ch.data_byte <= '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // directed: default timeout, no channel seen yet, so the tick is silent
      send_item(OP_TICK, 8'h00);
      send_frame(8'h00, STATION_ID, 8'h53, 8'hFF, 8'h7F, 8'hFF, 1'b0); // hottest, battery good
      send_frame(8'h40, STATION_ID, 8'hA3, 8'hFE, 8'hFF, 8'h00, 1'b0); // very cold, repeat channel
      send_frame(8'hBF, STATION_ID, 8'h0F, 8'h00, 8'h80, 8'h32, 1'b0); // negative zero
      send_frame(8'h12, STATION_ID, 8'h05, 8'h34, 8'h12, 8'h40, 1'b1); // checksum error
      send_frame(8'h12, 8'h41, 8'h06, 8'h34, 8'h12, 8'h40, 1'b0);      // foreign identifier
      send_item(OP_TICK, 8'hFF);

      // zero timeout: stale on the next tick, reported only once
      settle();
      write_timeout('0);
      send_item(OP_TICK, 8'h5A);
      send_item(OP_TICK, 8'hA5);
      send_frame(8'h01, STATION_ID, 8'h03, 8'h10, 8'h01, 8'h22, 1'b0);
      send_item(OP_TICK, 8'h00);

      // age a channel under the largest timeout, then lower it
      settle();
      write_timeout('1);
      send_frame(8'h00, STATION_ID, 8'h00, 8'h64, 8'h00, 8'h37, 1'b0);
      repeat (AGING_TICKS) send_item(OP_TICK, 8'($urandom));
      settle();
      write_timeout(16'd1);
      send_item(OP_TICK, 8'h00);

      // random traffic under different pacing
      run_phase(0, 0, 16'd2, 1'b1);
      run_phase(86, 0, 16'd1, 1'b0);
      run_phase(0, 86, 16'd0, 1'b0);
      run_phase(20, 20, 16'd3, 1'b0);

      settle();
      if (fail_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
